>>> hw/rtl/tbh_pkg.sv
`default_nettype none

package tbh_pkg;

  localparam int NUM_BINS    = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int BIN_W       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  localparam int CMD_W       = 2;
  localparam int BYTE_W      = 8;
  localparam int SEL_W       = 4;
  localparam int RPM_W       = 16;
  localparam int TEMP_W      = 12;
  localparam int TWID_W      = 8;
  localparam int RWID_W      = 12;
  localparam int OUT_CNT_W   = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int CMP_W       = (BIN_W > SEL_W) ? BIN_W : SEL_W;

  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_BASE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_WIDTH  = 2'd3;

  localparam logic [TEMP_W-1:0] TEMP_BASE_RST  = 12'd140;
  localparam logic [TWID_W-1:0] TEMP_WIDTH_RST = 8'd40;
  localparam logic [RPM_W-1:0]  RPM_BASE_RST   = 16'd550;
  localparam logic [RWID_W-1:0] RPM_WIDTH_RST  = 12'd135;

  localparam logic [TEMP_W-1:0] TENTHS_PER_DEG = 12'd10;

  typedef struct packed {
    logic                   valid;
    logic [CMD_W-1:0]       cmd;
    logic [RPM_W-1:0]       fan_speed;
    logic [TEMP_W-1:0]      temp_tenths;
    logic [TEMP_W-1:0]      t_diff;
    logic                   t_live;
    logic                   t_hit;
    logic [BIN_W-1:0]       t_bin;
    logic [RPM_W-1:0]       r_diff;
    logic                   r_live;
    logic                   r_hit;
    logic [BIN_W-1:0]       r_bin;
    logic [SEL_W-1:0]       read_bin;
    logic [COUNT_WIDTH-1:0] t_cnt;
    logic [COUNT_WIDTH-1:0] r_cnt;
  } tbh_stage_t;

endpackage

`default_nettype wire

>>> hw/rtl/tbh_if.sv
`default_nettype none

interface tbh_in_if;
  logic                       valid;
  logic                       ready;
  logic [tbh_pkg::CMD_W-1:0]  cmd;
  logic [tbh_pkg::BYTE_W-1:0] fan_speed_high;
  logic [tbh_pkg::BYTE_W-1:0] fan_speed_low;
  logic [tbh_pkg::BYTE_W-1:0] temp_whole;
  logic [tbh_pkg::BYTE_W-1:0] temp_tenth_part;
  logic [tbh_pkg::SEL_W-1:0]  read_bin;

  modport source (output valid, cmd, fan_speed_high, fan_speed_low, temp_whole,
                  temp_tenth_part, read_bin, input ready);
  modport sink (input valid, cmd, fan_speed_high, fan_speed_low, temp_whole,
                temp_tenth_part, read_bin, output ready);
endinterface

interface tbh_out_if;
  logic                          valid;
  logic                          ready;
  logic [tbh_pkg::RPM_W-1:0]     fan_speed;
  logic [tbh_pkg::TEMP_W-1:0]    temp_tenths;
  logic                          temp_hit;
  logic [tbh_pkg::SEL_W-1:0]     temp_bin;
  logic                          rpm_hit;
  logic [tbh_pkg::SEL_W-1:0]     rpm_bin;
  logic [tbh_pkg::OUT_CNT_W-1:0] temp_count_out;
  logic [tbh_pkg::OUT_CNT_W-1:0] rpm_count_out;

  modport source (output valid, fan_speed, temp_tenths, temp_hit, temp_bin, rpm_hit,
                  rpm_bin, temp_count_out, rpm_count_out, input ready);
  modport sink (input valid, fan_speed, temp_tenths, temp_hit, temp_bin, rpm_hit,
                rpm_bin, temp_count_out, rpm_count_out, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tbh_cell.sv
`default_nettype none

module tbh_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic [tbh_pkg::BIN_W-1:0]   bin_idx,
  input  wire logic [tbh_pkg::TWID_W-1:0]  t_width,
  input  wire logic [tbh_pkg::RWID_W-1:0]  r_width,
  input  wire tbh_pkg::tbh_stage_t         stage_in,
  output tbh_pkg::tbh_stage_t              stage_out
);
  import tbh_pkg::*;

  logic [COUNT_WIDTH-1:0] t_cnt_r, t_cnt_nxt;
  logic [COUNT_WIDTH-1:0] r_cnt_r, r_cnt_nxt;
  tbh_stage_t             stage_r, stage_nxt;
  logic                   t_in_bin, r_in_bin;
  logic                   is_rec, is_clr, is_rd;

  assign is_rec   = stage_in.valid && (stage_in.cmd == CMD_RECORD);
  assign is_clr   = stage_in.valid && (stage_in.cmd == CMD_CLEAR);
  assign is_rd    = stage_in.valid && (stage_in.cmd == CMD_READ)
                    && (CMP_W'(stage_in.read_bin) == CMP_W'(bin_idx));
  assign t_in_bin = stage_in.t_live && (stage_in.t_diff < TEMP_W'(t_width));
  assign r_in_bin = stage_in.r_live && (stage_in.r_diff < RPM_W'(r_width));

  always_comb begin
    t_cnt_nxt = t_cnt_r;
    r_cnt_nxt = r_cnt_r;
    if (is_clr) begin
      t_cnt_nxt = '0;
      r_cnt_nxt = '0;
    end else if (is_rec) begin
      if (t_in_bin && (t_cnt_r != '1)) begin
        t_cnt_nxt = t_cnt_r + COUNT_WIDTH'(1);
      end
      if (r_in_bin && (r_cnt_r != '1)) begin
        r_cnt_nxt = r_cnt_r + COUNT_WIDTH'(1);
      end
    end
  end

  always_comb begin
    stage_nxt        = stage_in;
    stage_nxt.t_diff = stage_in.t_diff - TEMP_W'(t_width);
    stage_nxt.r_diff = stage_in.r_diff - RPM_W'(r_width);
    stage_nxt.t_live = stage_in.t_live && !t_in_bin;
    stage_nxt.r_live = stage_in.r_live && !r_in_bin;
    if (t_in_bin) begin
      stage_nxt.t_hit = 1'b1;
      stage_nxt.t_bin = bin_idx;
    end
    if (r_in_bin) begin
      stage_nxt.r_hit = 1'b1;
      stage_nxt.r_bin = bin_idx;
    end
    if (is_rd) begin
      stage_nxt.t_cnt = t_cnt_r;
      stage_nxt.r_cnt = r_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_cnt_r <= '0;
      r_cnt_r <= '0;
      stage_r.valid <= 1'b0;
    end else if (adv) begin
      t_cnt_r <= t_cnt_nxt;
      r_cnt_r <= r_cnt_nxt;
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;

endmodule

`default_nettype wire

>>> hw/rtl/telemetry_bin_histogram_core.sv
`default_nettype none
// Channel   Role      Payload
// in_ch     sink      cmd, fan_speed_high/low, temp_whole, temp_tenth_part, read_bin
// out_ch    source    fan_speed, temp_tenths, hits, bins, temp/rpm counts
// cfg_*     write     cfg_we, cfg_index, cfg_wdata (no read-back)
//
// One transfer per cycle while out_ch is not stalled; each item visits every bin cell.
// Each cell owns one bin of both histograms and updates it as an item passes through.
// The last cell's stage register is the output register.
// A stalled output freezes the whole chain; in_ch.ready falls only while it is stalled.
// Synchronous reset clears every counter and restores the register defaults.

module telemetry_bin_histogram_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  tbh_in_if.sink                              in_ch,
  tbh_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [tbh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tbh_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tbh_pkg::*;

  logic [TEMP_W-1:0] t_base_r;
  logic [TWID_W-1:0] t_width_r;
  logic [RPM_W-1:0]  r_base_r;
  logic [RWID_W-1:0] r_width_r;

  tbh_stage_t        chain [NUM_BINS+1];
  tbh_stage_t        head;
  tbh_stage_t        last;
  logic              adv;
  logic              rec_out;
  logic [RPM_W-1:0]  fan_in;
  logic [TEMP_W-1:0] temp_in;
  logic              rec_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_base_r  <= TEMP_BASE_RST;
      t_width_r <= TEMP_WIDTH_RST;
      r_base_r  <= RPM_BASE_RST;
      r_width_r <= RPM_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_BASE:  t_base_r  <= cfg_wdata[TEMP_W-1:0];
        REG_TEMP_WIDTH: t_width_r <= cfg_wdata[TWID_W-1:0];
        REG_RPM_BASE:   r_base_r  <= cfg_wdata[RPM_W-1:0];
        REG_RPM_WIDTH:  r_width_r <= cfg_wdata[RWID_W-1:0];
        default: ;
      endcase
    end
  end

  assign last = chain[NUM_BINS];
  assign adv  = !last.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // decode the sample ahead of bin zero
  assign fan_in  = {in_ch.fan_speed_high, in_ch.fan_speed_low};
  assign temp_in = TEMP_W'(in_ch.temp_whole) * TENTHS_PER_DEG + TEMP_W'(in_ch.temp_tenth_part);
  assign rec_in  = in_ch.cmd == CMD_RECORD;

  always_comb begin
    head.valid       = in_ch.valid;
    head.cmd         = in_ch.cmd;
    head.fan_speed   = fan_in;
    head.temp_tenths = temp_in;
    head.t_diff      = temp_in - t_base_r;
    head.t_live      = rec_in && (temp_in >= t_base_r) && (t_width_r != '0);
    head.t_hit       = 1'b0;
    head.t_bin       = '0;
    head.r_diff      = fan_in - r_base_r;
    head.r_live      = rec_in && (fan_in >= r_base_r) && (r_width_r != '0);
    head.r_hit       = 1'b0;
    head.r_bin       = '0;
    head.read_bin    = in_ch.read_bin;
    head.t_cnt       = '0;
    head.r_cnt       = '0;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < NUM_BINS; i++) begin : g_cell
    tbh_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .bin_idx   (BIN_W'(i)),
      .t_width   (t_width_r),
      .r_width   (r_width_r),
      .stage_in  (chain[i]),
      .stage_out (chain[i+1])
    );
  end

  assign rec_out               = last.cmd == CMD_RECORD;
  assign out_ch.valid          = last.valid;
  assign out_ch.fan_speed      = rec_out ? last.fan_speed : '0;
  assign out_ch.temp_tenths    = rec_out ? last.temp_tenths : '0;
  assign out_ch.temp_hit       = last.t_hit;
  assign out_ch.temp_bin       = SEL_W'(last.t_bin);
  assign out_ch.rpm_hit        = last.r_hit;
  assign out_ch.rpm_bin        = SEL_W'(last.r_bin);
  assign out_ch.temp_count_out = OUT_CNT_W'(last.t_cnt);
  assign out_ch.rpm_count_out  = OUT_CNT_W'(last.r_cnt);

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(chain[1]) && $stable(last))
    else $error("chain moved while output stalled");

  a_hit_only_record: assert property (@(posedge clk) disable iff (!rst_n)
    last.valid && !rec_out |-> !last.t_hit && !last.r_hit)
    else $error("bin hit on a non-record item");

  a_count_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    last.valid && (last.cmd != CMD_READ) |-> (last.t_cnt == '0) && (last.r_cnt == '0))
    else $error("count returned on a non-read item");

  a_empty_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !last.valid)
    else $error("result present straight after reset");

endmodule

`default_nettype wire

>>> verif/telemetry_bin_histogram_core_test.sv
`timescale 1ns / 1ps

module telemetry_bin_histogram_core_test;
  import tbh_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int unsigned TEMP_MAX    = 2805;
  localparam int unsigned RPM_MAX     = 65535;
  localparam int unsigned LATENCY     = NUM_BINS;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 17;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] fan_hi;
    logic [BYTE_W-1:0] fan_lo;
    logic [BYTE_W-1:0] temp_whole;
    logic [BYTE_W-1:0] temp_tenth;
    logic [SEL_W-1:0]  read_bin;
  } telemetry_req_t;

  typedef struct packed {
    logic [RPM_W-1:0]     fan_speed;
    logic [TEMP_W-1:0]    temp_tenths;
    logic                 temp_hit;
    logic [SEL_W-1:0]     temp_bin;
    logic                 rpm_hit;
    logic [SEL_W-1:0]     rpm_bin;
    logic [OUT_CNT_W-1:0] temp_count;
    logic [OUT_CNT_W-1:0] rpm_count;
  } bin_readout_t;

  class histogram_mirror;
    logic [COUNT_WIDTH-1:0] temp_tally [NUM_BINS];
    logic [COUNT_WIDTH-1:0] fan_tally [NUM_BINS];
    int unsigned temp_base;
    int unsigned temp_width;
    int unsigned fan_base;
    int unsigned fan_width;
    bin_readout_t expected_readouts [$];
    int unsigned mismatches;

    function new();
      clear_tallies();
      temp_base  = 32'(TEMP_BASE_RST);
      temp_width = 32'(TEMP_WIDTH_RST);
      fan_base   = 32'(RPM_BASE_RST);
      fan_width  = 32'(RPM_WIDTH_RST);
      mismatches = 0;
    endfunction

    function void clear_tallies();
      foreach (temp_tally[i]) begin
        temp_tally[i] = '0;
        fan_tally[i]  = '0;
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TEMP_BASE:  temp_base  = 32'(data[TEMP_W-1:0]);
        REG_TEMP_WIDTH: temp_width = 32'(data[TWID_W-1:0]);
        REG_RPM_BASE:   fan_base   = 32'(data[RPM_W-1:0]);
        REG_RPM_WIDTH:  fan_width  = 32'(data[RWID_W-1:0]);
        default: ;
      endcase
    endfunction

    function void locate(int unsigned sample, int unsigned base, int unsigned width,
                         output bit hit, output int unsigned idx);
      int unsigned q;
      hit = 1'b0;
      idx = 0;
      if (width == 0 || sample < base) return;
      q = (sample - base) / width;
      if (q >= NUM_BINS) return;
      hit = 1'b1;
      idx = q;
    endfunction

    function void note_transfer(telemetry_req_t req);
      bin_readout_t r;
      int unsigned fan;
      int unsigned temp;
      int unsigned t_idx;
      int unsigned f_idx;
      bit t_hit;
      bit f_hit;
      r = '0;
      case (req.cmd)
        CMD_RECORD: begin
          fan  = 32'({req.fan_hi, req.fan_lo});
          temp = int'(req.temp_whole) * int'(TENTHS_PER_DEG) + int'(req.temp_tenth);
          locate(temp, temp_base, temp_width, t_hit, t_idx);
          locate(fan, fan_base, fan_width, f_hit, f_idx);
          if (t_hit && temp_tally[t_idx] != '1)
            temp_tally[t_idx] = temp_tally[t_idx] + COUNT_WIDTH'(1);
          if (f_hit && fan_tally[f_idx] != '1)
            fan_tally[f_idx] = fan_tally[f_idx] + COUNT_WIDTH'(1);
          r.fan_speed   = fan[RPM_W-1:0];
          r.temp_tenths = temp[TEMP_W-1:0];
          r.temp_hit    = t_hit;
          r.temp_bin    = t_idx[SEL_W-1:0];
          r.rpm_hit     = f_hit;
          r.rpm_bin     = f_idx[SEL_W-1:0];
        end
        CMD_CLEAR: clear_tallies();
        CMD_READ: begin
          if (req.read_bin < NUM_BINS) begin
            r.temp_count = temp_tally[req.read_bin][OUT_CNT_W-1:0];
            r.rpm_count  = fan_tally[req.read_bin][OUT_CNT_W-1:0];
          end
        end
        default: ;
      endcase
      expected_readouts.push_back(r);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(bin_readout_t got);
      bin_readout_t want;
      if (expected_readouts.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $time);
        mismatches++;
        return;
      end
      want = expected_readouts.pop_front();
      compare("fan_speed", 64'(want.fan_speed), 64'(got.fan_speed));
      compare("temp_tenths", 64'(want.temp_tenths), 64'(got.temp_tenths));
      compare("temp_hit", 64'(want.temp_hit), 64'(got.temp_hit));
      compare("temp_bin", 64'(want.temp_bin), 64'(got.temp_bin));
      compare("rpm_hit", 64'(want.rpm_hit), 64'(got.rpm_hit));
      compare("rpm_bin", 64'(want.rpm_bin), 64'(got.rpm_bin));
      compare("temp_count_out", 64'(want.temp_count), 64'(got.temp_count));
      compare("rpm_count_out", 64'(want.rpm_count), 64'(got.rpm_count));
    endfunction

    function int unsigned pending();
      return expected_readouts.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit steady;
  int unsigned cycles = 0;
  histogram_mirror board = new();

  tbh_in_if in_ch();
  tbh_out_if out_ch();

  telemetry_bin_histogram_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : watch_results
    bin_readout_t seen;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.fan_speed   = out_ch.fan_speed;
      seen.temp_tenths = out_ch.temp_tenths;
      seen.temp_hit    = out_ch.temp_hit;
      seen.temp_bin    = out_ch.temp_bin;
      seen.rpm_hit     = out_ch.rpm_hit;
      seen.rpm_bin     = out_ch.rpm_bin;
      seen.temp_count  = out_ch.temp_count_out;
      seen.rpm_count   = out_ch.rpm_count_out;
      board.check_result(seen);
    end
  end

  function automatic telemetry_req_t req_of(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] fan_hi,
                                            logic [BYTE_W-1:0] fan_lo,
                                            logic [BYTE_W-1:0] whole,
                                            logic [BYTE_W-1:0] tenth,
                                            logic [SEL_W-1:0] bin);
    telemetry_req_t req;
    req.cmd        = cmd;
    req.fan_hi     = fan_hi;
    req.fan_lo     = fan_lo;
    req.temp_whole = whole;
    req.temp_tenth = tenth;
    req.read_bin   = bin;
    return req;
  endfunction

  // aim samples at the configured bins, with a margin either side
  function automatic telemetry_req_t aimed_record();
    telemetry_req_t req;
    int unsigned lo;
    int unsigned hi;
    int unsigned t;
    int unsigned f;
    int unsigned k;
    int unsigned kmin;
    int unsigned kmax;
    req = req_of(CMD_RECORD, '0, '0, '0, '0, SEL_W'($urandom));
    lo = (board.temp_base > board.temp_width) ? board.temp_base - board.temp_width : 0;
    hi = board.temp_base + board.temp_width * (NUM_BINS + 1);
    if (hi > TEMP_MAX) hi = TEMP_MAX;
    if (lo > hi) lo = hi;
    t = $urandom_range(hi, lo);
    kmin = (t / 10 > 255) ? t / 10 - 255 : 0;
    kmax = (255 - t % 10) / 10;
    if (kmax > t / 10) kmax = t / 10;
    k = ($urandom_range(7) == 0) ? $urandom_range(kmax, kmin) : kmin;
    req.temp_whole = BYTE_W'(t / 10 - k);
    req.temp_tenth = BYTE_W'(t % 10 + 10 * k);
    lo = (board.fan_base > board.fan_width) ? board.fan_base - board.fan_width : 0;
    hi = board.fan_base + board.fan_width * (NUM_BINS + 1);
    if (hi > RPM_MAX) hi = RPM_MAX;
    if (lo > hi) lo = hi;
    f = $urandom_range(hi, lo);
    {req.fan_hi, req.fan_lo} = f[RPM_W-1:0];
    return req;
  endfunction

  task automatic send(telemetry_req_t req);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.cmd             <= req.cmd;
    in_ch.fan_speed_high  <= req.fan_hi;
    in_ch.fan_speed_low   <= req.fan_lo;
    in_ch.temp_whole      <= req.temp_whole;
    in_ch.temp_tenth_part <= req.temp_tenth;
    in_ch.read_bin        <= req.read_bin;
    do @(posedge clk); while (!in_ch.ready);
    board.note_transfer(req);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int unsigned data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_register(idx, data[CFG_DATA_W-1:0]);
  endtask

  task automatic configure(int unsigned t_base, int unsigned t_width,
                           int unsigned f_base, int unsigned f_width);
    settle();
    write_register(REG_TEMP_BASE, t_base);
    write_register(REG_TEMP_WIDTH, t_width);
    write_register(REG_RPM_BASE, f_base);
    write_register(REG_RPM_WIDTH, f_width);
  endtask

  task automatic random_phase(int unsigned count);
    telemetry_req_t req;
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(99);
      req  = req_of(CMD_READ, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                    BYTE_W'($urandom), SEL_W'($urandom));
      if (roll < 8) req.cmd = CMD_RECORD;
      else if (roll < 72) req = aimed_record();
      else if (roll < 87) req.cmd = CMD_READ;
      else if (roll < 90) req.cmd = CMD_CLEAR;
      else if (roll < 93) req.cmd = CMD_SPARE;
      send(req);
    end
  endtask

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = REG_TEMP_BASE;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.cmd             = CMD_RECORD;
    in_ch.fan_speed_high  = '0;
    in_ch.fan_speed_low   = '0;
    in_ch.temp_whole      = '0;
    in_ch.temp_tenth_part = '0;
    in_ch.read_bin        = '0;
    out_ch.ready          = 1'b0;
    steady                = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(req_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0));
    send(req_of(CMD_RECORD, 8'h00, 8'h00, 8'd0, 8'd0, 4'd0));
    send(req_of(CMD_RECORD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'hF));
    send(req_of(CMD_RECORD, 8'h02, 8'h26, 8'd14, 8'd0, 4'd0));
    send(req_of(CMD_RECORD, 8'h02, 8'hAC, 8'd17, 8'd9, 4'd0));
    send(req_of(CMD_RECORD, 8'h02, 8'hAD, 8'd18, 8'd0, 4'd0));
    send(req_of(CMD_RECORD, 8'h0A, 8'h95, 8'd77, 8'd9, 4'd0));
    send(req_of(CMD_RECORD, 8'h0A, 8'h96, 8'd78, 8'd0, 4'd0));
    send(req_of(CMD_RECORD, 8'h02, 8'h25, 8'd13, 8'd9, 4'd0));
    send(req_of(CMD_RECORD, 8'hAA, 8'h55, 8'd10, 8'd200, 4'd0));
    send(req_of(CMD_RECORD, 8'h55, 8'hAA, 8'hAA, 8'h55, 4'd0));
    send(req_of(CMD_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd0));
    send(req_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 4'd1));
    send(req_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 4'd4));
    send(req_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 4'd15));
    send(req_of(CMD_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'hF));
    send(req_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0));
    send(req_of(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'hF));
    send(req_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0));
    send(req_of(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 4'd15));

    random_phase(100);
    configure(0, 1, 0, 1);
    random_phase(100);
    configure(TEMP_MAX, 255, RPM_MAX, 4095);
    random_phase(100);
    // zero widths: nothing may be counted
    configure(200, 0, 3000, 0);
    random_phase(60);
    configure($urandom_range(TEMP_MAX), $urandom_range(255, 1), $urandom_range(RPM_MAX),
              $urandom_range(4095, 1));
    random_phase(120);
    // drop the upper bits of each write word
    configure($urandom_range(RPM_MAX), $urandom_range(RPM_MAX), $urandom_range(RPM_MAX),
              $urandom_range(RPM_MAX));
    random_phase(100);
    // hold both sides busy for a full stretch
    steady = 1'b1;
    configure($urandom_range(TEMP_MAX), $urandom_range(255, 1), $urandom_range(RPM_MAX),
              $urandom_range(4095, 1));
    random_phase(120);
    steady = 1'b0;
    configure(32'(TEMP_BASE_RST), 32'(TEMP_WIDTH_RST), 32'(RPM_BASE_RST),
              32'(RPM_WIDTH_RST));
    random_phase(100);
    settle();

    if (board.mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/tbh_pkg.sv
hw/rtl/tbh_if.sv
hw/rtl/tbh_cell.sv
hw/rtl/telemetry_bin_histogram_core.sv
verif/telemetry_bin_histogram_core_test.sv
